>>> rtl/lsw_pkg.sv
// shared types, constants and register codes for the lcd serial window framer
package lsw_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned BYTES_PER_ROW = 16;
  localparam int unsigned HALF_ROWS = 32;
  localparam int unsigned LOWER_HALF_WORD_OFFSET = 8;
  localparam int unsigned WORDS_IN_ROW = BYTES_PER_ROW / 2;

  localparam int unsigned ROW_W = $clog2((2 ** IDX_W) / BYTES_PER_ROW);
  localparam int unsigned COL_W = $clog2(BYTES_PER_ROW);
  localparam int unsigned WSUM_W = $clog2(WORDS_IN_ROW) + 2;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WORD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT = 2'd3;

  localparam logic [BYTE_W-1:0] SYNC_CMD = 8'hF8;
  localparam logic [BYTE_W-1:0] SYNC_DATA = 8'hFA;
  localparam logic [BYTE_W-1:0] ADDR_CMD = 8'h80;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'hF0;

  localparam logic [1:0] TRIP_ROW = 2'd0;
  localparam logic [1:0] TRIP_COL = 2'd1;
  localparam logic [1:0] TRIP_DATA = 2'd2;

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_HI = 2'd1;
  localparam logic [1:0] PH_LO = 2'd2;

  typedef struct packed {
    logic [5:0] first_row;
    logic [5:0] last_row;
    logic [2:0] first_word;
    logic [3:0] word_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_row: 6'd0,
    last_row: 6'd63,
    first_word: 3'd0,
    word_count: 4'd8
  };

  typedef struct packed {
    logic [BYTE_W-1:0] row_cmd;
    logic [BYTE_W-1:0] col_cmd;
    logic [PIX_W-1:0]  pix;
    logic              row_start;
    logic              at_end;
  } desc_t;

endpackage

>>> rtl/lsw_in_if.sv
// input channel: frame buffer byte and its index
interface lsw_in_if;
  logic                       valid;
  logic                       ready;
  logic [lsw_pkg::IDX_W-1:0]  byte_index;
  logic [lsw_pkg::PIX_W-1:0]  pixel_byte;

  modport source(output valid, output byte_index, output pixel_byte, input ready);
  modport sink(input valid, input byte_index, input pixel_byte, output ready);
endinterface

>>> rtl/lsw_out_if.sv
// output channel: serial link bytes with run and window flags
interface lsw_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsw_pkg::BYTE_W-1:0]  wire_byte;
  logic                        last_in_run;
  logic                        window_end;

  modport source(output valid, output wire_byte, output last_in_run, output window_end,
                 input ready);
  modport sink(input valid, input wire_byte, input last_in_run, input window_end,
               output ready);
endinterface

>>> rtl/lsw_front.sv
// front end: window registers, window test and command byte build
module lsw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lsw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lsw_in_if.sink                           in_i,
  input  logic                             full_i,
  output logic                             push_o,
  output lsw_pkg::desc_t                   desc_o
);

  lsw_pkg::cfg_t                     cfg_q;
  logic [lsw_pkg::IDX_W-1:0]         row_full;
  logic [lsw_pkg::IDX_W-1:0]         col_full;
  logic [lsw_pkg::ROW_W-1:0]         row;
  logic [lsw_pkg::COL_W-1:0]         col;
  logic [lsw_pkg::WSUM_W-1:0]        fw_ext;
  logic [lsw_pkg::WSUM_W-1:0]        avail;
  logic [lsw_pkg::WSUM_W-1:0]        count;
  logic [lsw_pkg::WSUM_W:0]          col_lo;
  logic [lsw_pkg::WSUM_W:0]          col_hi;
  logic [lsw_pkg::WSUM_W:0]          col_ext;
  logic                              win_ok;
  logic                              in_win;
  logic                              lower;
  logic [lsw_pkg::BYTE_W-1:0]        raddr;
  logic [lsw_pkg::BYTE_W-1:0]        waddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lsw_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsw_pkg::CFG_FIRST_ROW:  cfg_q.first_row <= cfg_data_i[5:0];
        lsw_pkg::CFG_LAST_ROW:   cfg_q.last_row <= cfg_data_i[5:0];
        lsw_pkg::CFG_FIRST_WORD: cfg_q.first_word <= cfg_data_i[2:0];
        lsw_pkg::CFG_WORD_COUNT: cfg_q.word_count <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    row_full = lsw_pkg::IDX_W'(in_i.byte_index / lsw_pkg::BYTES_PER_ROW);
    col_full = lsw_pkg::IDX_W'(in_i.byte_index % lsw_pkg::BYTES_PER_ROW);
    row      = row_full[lsw_pkg::ROW_W-1:0];
    col      = col_full[lsw_pkg::COL_W-1:0];

    fw_ext = lsw_pkg::WSUM_W'(cfg_q.first_word);
    avail  = lsw_pkg::WSUM_W'(lsw_pkg::WORDS_IN_ROW) - fw_ext;
    if (lsw_pkg::WSUM_W'(cfg_q.word_count) > avail) begin
      count = avail;
    end else begin
      count = lsw_pkg::WSUM_W'(cfg_q.word_count);
    end
    col_lo  = {fw_ext, 1'b0};
    col_hi  = {fw_ext + count, 1'b0};
    col_ext = (lsw_pkg::WSUM_W + 1)'(col);

    win_ok = (fw_ext < lsw_pkg::WSUM_W'(lsw_pkg::WORDS_IN_ROW)) && (count != '0)
             && (cfg_q.first_row <= cfg_q.last_row);
    in_win = win_ok && (row >= cfg_q.first_row) && (row <= cfg_q.last_row)
             && (col_ext >= col_lo) && (col_ext < col_hi);

    lower = (lsw_pkg::BYTE_W'(row) >= lsw_pkg::BYTE_W'(lsw_pkg::HALF_ROWS));
    if (lower) begin
      raddr = lsw_pkg::BYTE_W'(row) - lsw_pkg::BYTE_W'(lsw_pkg::HALF_ROWS);
      waddr = lsw_pkg::BYTE_W'(cfg_q.first_word)
              + lsw_pkg::BYTE_W'(lsw_pkg::LOWER_HALF_WORD_OFFSET);
    end else begin
      raddr = lsw_pkg::BYTE_W'(row);
      waddr = lsw_pkg::BYTE_W'(cfg_q.first_word);
    end

    desc_o.row_cmd   = lsw_pkg::ADDR_CMD | raddr;
    desc_o.col_cmd   = lsw_pkg::ADDR_CMD | waddr;
    desc_o.pix       = in_i.pixel_byte;
    desc_o.row_start = (col_ext == col_lo);
    desc_o.at_end    = (row == cfg_q.last_row) && (col_ext == col_hi - 1'b1);
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && in_win;

endmodule

>>> rtl/lsw_queue.sv
// short first-word-fall-through queue of framed items between front and back
module lsw_queue #(
  parameter int unsigned DEPTH = lsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lsw_pkg::desc_t  desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output lsw_pkg::desc_t  desc_o,
  output logic            empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lsw_pkg::desc_t     mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_cnt_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");

endmodule

>>> rtl/lsw_back.sv
// back end: expands a queued item into sync and nibble bytes on the output register
module lsw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lsw_pkg::desc_t  desc_i,
  input  logic            empty_i,
  output logic            pop_o,
  lsw_out_if.source       out_o
);

  logic                        out_valid_q;
  logic [lsw_pkg::BYTE_W-1:0]  wire_byte_q;
  logic                        last_q;
  logic                        end_q;
  logic                        first_q;
  logic [1:0]                  trip_q;
  logic [1:0]                  phase_q;
  logic                        load;
  logic [1:0]                  trip;
  logic [lsw_pkg::BYTE_W-1:0]  cur;
  logic [lsw_pkg::BYTE_W-1:0]  sync;
  logic [lsw_pkg::BYTE_W-1:0]  byte_d;
  logic                        is_last;

  always_comb begin
    load = !empty_i && (!out_valid_q || out_o.ready);
    if (first_q) begin
      trip = desc_i.row_start ? lsw_pkg::TRIP_ROW : lsw_pkg::TRIP_DATA;
    end else begin
      trip = trip_q;
    end
    case (trip)
      lsw_pkg::TRIP_ROW: cur = desc_i.row_cmd;
      lsw_pkg::TRIP_COL: cur = desc_i.col_cmd;
      default:           cur = desc_i.pix;
    endcase
    sync = (trip == lsw_pkg::TRIP_DATA) ? lsw_pkg::SYNC_DATA : lsw_pkg::SYNC_CMD;
    case (phase_q)
      lsw_pkg::PH_SYNC: byte_d = sync;
      lsw_pkg::PH_HI:   byte_d = cur & lsw_pkg::NIBBLE_MASK;
      lsw_pkg::PH_LO:   byte_d = {cur[3:0], 4'b0000};
      default:          byte_d = sync;
    endcase
    is_last = (trip == lsw_pkg::TRIP_DATA) && (phase_q == lsw_pkg::PH_LO);
  end

  assign pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      first_q     <= 1'b1;
      trip_q      <= lsw_pkg::TRIP_ROW;
      phase_q     <= lsw_pkg::PH_SYNC;
    end else if (load) begin
      out_valid_q <= 1'b1;
      if (is_last) begin
        first_q <= 1'b1;
        phase_q <= lsw_pkg::PH_SYNC;
        trip_q  <= lsw_pkg::TRIP_ROW;
      end else if (phase_q == lsw_pkg::PH_LO) begin
        first_q <= 1'b0;
        phase_q <= lsw_pkg::PH_SYNC;
        trip_q  <= trip + 1'b1;
      end else begin
        first_q <= 1'b0;
        phase_q <= phase_q + 1'b1;
        trip_q  <= trip;
      end
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      wire_byte_q <= byte_d;
      last_q      <= is_last;
      end_q       <= is_last && desc_i.at_end;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.wire_byte   = wire_byte_q;
  assign out_o.last_in_run = last_q;
  assign out_o.window_end  = end_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.window_end) |-> out_o.last_in_run)
    else $error("window end without end of run");

  a_trip_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> (trip_q == lsw_pkg::TRIP_ROW || trip_q == lsw_pkg::TRIP_COL
                  || trip_q == lsw_pkg::TRIP_DATA))
    else $error("byte group counter out of range");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> !empty_i)
    else $error("queue head lost in the middle of an item");

endmodule

>>> rtl/lcd_serial_window_framer.sv
// top level of the lcd serial window framer
// Each frame buffer byte inside the row and word window comes out as three link bytes
// (sync, high nibble, low nibble), and the first window byte of a row as nine, adding
// the row and column address commands. The single output register issues one byte a
// cycle while the receiver is ready and a queued item waits. A byte outside the window
// is taken and gives nothing. The front end classifies each input in the cycle it
// arrives and keeps taking input while a queue of QUEUE_DEPTH framed items has room, so
// input and output stall independently. Window registers must be written through the
// plain write port while the block is idle; the block itself does not enforce this.
module lcd_serial_window_framer #(
  parameter int unsigned QUEUE_DEPTH = lsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lsw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lsw_in_if.sink                          in_i,
  lsw_out_if.source                       out_o
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  lsw_pkg::desc_t  push_desc;
  lsw_pkg::desc_t  head_desc;

  lsw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  lsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .desc_o  (head_desc),
    .empty_o (empty)
  );

  lsw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .desc_i  (head_desc),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
